// ===== src/stbs_pkg.sv =====
// types and constants shared by the sorted table search core
package stbs_pkg;

	localparam int CFG_W   = 11;
	localparam int ENTRY_W = 10;
	localparam int KEY_W   = 32;
	localparam int POS_W   = 10;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_SEARCH = 1'b1;

	typedef struct packed {
		logic                    action;
		logic [ENTRY_W-1:0]      entry_index;
		logic signed [KEY_W-1:0] key_value;
	} stbs_in_t;

	typedef struct packed {
		logic             found;
		logic [POS_W-1:0] position;
	} stbs_out_t;

endpackage

// ===== src/sorted_table_binary_search_core.sv =====
// binary search over a sorted key table held in one ram
//
// channel  direction  payload     handshake
// in       to core    stbs_in_t   in_valid / in_stall
// out      from core  stbs_out_t  out_valid / out_stall
// cfg      to core    11 bits     cfg_wr_en / cfg_wr_data
//
// a load is written to the ram at its transfer and the core stays idle; a search reads
// one table probe at a time through the single ram read port until a hit or an empty range
// an empty table skips the ram and the result goes through the finish state
// arst_n clears control state; the table contents are undefined until loaded
// a finished result waits in the output register while out_stall is high
module sorted_table_binary_search_core
	import stbs_pkg::*;
#(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  stbs_in_t         in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output stbs_out_t        out_data,
	input  logic             cfg_wr_en,
	input  logic [CFG_W-1:0] cfg_wr_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int SW = AW + 2;
	localparam int XW = AW + CFG_W + ENTRY_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic [1:0]              state_q;
	logic [CFG_W-1:0]        cfg_q;
	logic                    out_valid_q;
	stbs_out_t               out_q;
	logic signed [SW-1:0]    lo_q;
	logic signed [SW-1:0]    hi_q;
	logic signed [SW-1:0]    mid_q;
	logic signed [KEY_W-1:0] key_q;
	logic                    res_found_q;
	logic [POS_W-1:0]        res_pos_q;

	logic                    in_fire;
	logic                    out_free;
	logic                    out_load;
	logic [XW-1:0]           cfg_wide;
	logic [XW-1:0]           count;
	logic signed [SW-1:0]    count_s;
	logic                    empty;
	logic [XW-1:0]           idx_wide;
	logic                    wr_en;
	logic signed [SW-1:0]    init_hi;
	logic signed [SW-1:0]    init_mid;
	logic [KEY_W-1:0]        rd_data;
	logic signed [KEY_W-1:0] probe;
	logic                    hit;
	logic                    stop;
	logic                    lt;
	logic signed [SW-1:0]    nxt_lo;
	logic signed [SW-1:0]    nxt_hi;
	logic signed [SW-1:0]    span;
	logic signed [SW-1:0]    nxt_mid;
	logic                    rd_en;
	logic signed [SW-1:0]    rd_mid;
	logic [SW+POS_W-1:0]     mid_wide;
	logic [POS_W-1:0]        hit_pos;
	logic                    search_fire;

	assign in_stall    = (state_q != ST_IDLE);
	assign in_fire     = in_valid && !in_stall;
	assign search_fire = in_fire && (in_data.action == ACT_SEARCH);
	assign out_free    = !out_valid_q || !out_stall;
	assign out_load    = ((state_q == ST_CMP) && stop && out_free) ||
	                     ((state_q == ST_FIN) && out_free);

	// effective entry count, saturated to the table depth
	assign cfg_wide = XW'(cfg_q);
	assign count    = (cfg_wide > XW'(TABLE_DEPTH)) ? XW'(TABLE_DEPTH) : cfg_wide;
	assign count_s  = SW'(count);
	assign empty    = (count == '0);
	assign init_hi  = count_s - SW'(1);
	assign init_mid = (init_hi > 0) ? (init_hi >>> 1) : '0;

	assign idx_wide = XW'(in_data.entry_index);
	assign wr_en    = in_fire && (in_data.action == ACT_LOAD) && (idx_wide < XW'(TABLE_DEPTH));

	// probe compare and next range
	assign probe   = $signed(rd_data);
	assign hit     = (probe == key_q);
	assign stop    = hit || (hi_q <= lo_q);
	assign lt      = (probe < key_q);
	assign nxt_lo  = lt ? (mid_q + SW'(1)) : lo_q;
	assign nxt_hi  = lt ? hi_q : (mid_q - SW'(1));
	assign span    = nxt_hi - nxt_lo;
	assign nxt_mid = nxt_lo + ((span > 0) ? (span >>> 1) : SW'(0));

	assign mid_wide = {{POS_W{1'b0}}, mid_q};
	assign hit_pos  = hit ? mid_wide[POS_W-1:0] : '0;

	always_comb begin
		rd_en  = 1'b0;
		rd_mid = init_mid;
		case (state_q)
			ST_IDLE: begin
				rd_en  = search_fire && !empty;
				rd_mid = init_mid;
			end
			ST_CMP: begin
				rd_en  = !stop;
				rd_mid = nxt_mid;
			end
			default: begin
				rd_en  = 1'b0;
				rd_mid = init_mid;
			end
		endcase
	end

	stbs_ram #(
		.WIDTH(KEY_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(idx_wide[AW-1:0]),
		.wr_data(in_data.key_value),
		.rd_en  (rd_en),
		.rd_addr(rd_mid[AW-1:0]),
		.rd_data(rd_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				cfg_q <= cfg_wr_data;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (search_fire) begin
						state_q <= empty ? ST_FIN : ST_CMP;
					end
				end
				ST_CMP: begin
					if (stop) begin
						if (out_free) begin
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (search_fire) begin
					key_q       <= in_data.key_value;
					lo_q        <= '0;
					hi_q        <= init_hi;
					mid_q       <= init_mid;
					res_found_q <= 1'b0;
					res_pos_q   <= '0;
				end
			end
			ST_CMP: begin
				if (stop) begin
					res_found_q <= hit;
					res_pos_q   <= hit_pos;
					if (out_free) begin
						out_q.found    <= hit;
						out_q.position <= hit_pos;
					end
				end else begin
					lo_q  <= nxt_lo;
					hi_q  <= nxt_hi;
					mid_q <= nxt_mid;
				end
			end
			ST_FIN: begin
				if (out_free) begin
					out_q.found    <= res_found_q;
					out_q.position <= res_pos_q;
				end
			end
			default: begin
				key_q <= key_q;
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_probe_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CMP |-> (mid_q >= 0) && (mid_q < count_s))
		else $error("probe index outside searched range");

	a_miss_pos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_q.found || (out_q.position == '0))
		else $error("miss reported with nonzero position");

	a_search_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		search_fire |=> state_q != ST_IDLE)
		else $error("search transfer did not start a search");

	a_result_on_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) && out_free |=> out_valid_q && (state_q == ST_IDLE))
		else $error("pending result not moved to output");

endmodule

// ===== src/stbs_ram.sv =====
// generic simple dual port ram with registered read
module stbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== test/sorted_table_binary_search_core_tb.sv =====
// testbench for the sorted table binary search core: loads, searches and count settings
`timescale 1ns / 100ps

module sorted_table_binary_search_core_tb;
	import stbs_pkg::*;

	localparam int TABLE_DEPTH  = 1024;
	localparam int ITEM_TARGET  = 1900;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int REPORT_MAX   = 10;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	stbs_in_t         in_data;
	logic             out_valid;
	logic             out_stall;
	stbs_out_t        out_data;
	logic             cfg_wr_en;
	logic [CFG_W-1:0] cfg_wr_data;

	logic signed [KEY_W-1:0] key_mirror [TABLE_DEPTH];
	int                      count_mirror;
	stbs_out_t               pending_answers [$];
	int                      items_sent;
	int                      mismatches;
	int                      cycle_count;
	bit                      in_idle_on;
	bit                      out_idle_on;
	int                      stall_left;
	stbs_out_t               wanted;

	sorted_table_binary_search_core #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int pick_gap(bit enabled);
		int r;
		r = $urandom_range(0, 99);
		if (!enabled || r < 60)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(4, 25);
	endfunction

	function automatic int halfway(int lo, int hi);
		return lo + ((hi > lo) ? (hi - lo) / 2 : 0);
	endfunction

	function automatic stbs_out_t predict_search(logic signed [KEY_W-1:0] key);
		stbs_out_t               answer;
		int                      n;
		int                      lo;
		int                      hi;
		int                      mid;
		logic signed [KEY_W-1:0] probe;
		answer = '0;
		n = (count_mirror > TABLE_DEPTH) ? TABLE_DEPTH : count_mirror;
		if (n <= 0)
			return answer;
		lo = 0;
		hi = n - 1;
		mid = halfway(lo, hi);
		forever begin
			if (mid < 0 || mid >= n)
				break;
			probe = key_mirror[mid];
			if (probe == key) begin
				answer.found    = 1'b1;
				answer.position = POS_W'(mid);
				break;
			end
			if (hi <= lo)
				break;
			if (probe < key)
				lo = mid + 1;
			else
				hi = mid - 1;
			mid = halfway(lo, hi);
		end
		return answer;
	endfunction

	task automatic send_item(input stbs_in_t item);
		int gap;
		gap = pick_gap(in_idle_on);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= item;
		do
			@(posedge clk);
		while (in_stall);
		if (item.action == ACT_LOAD)
			key_mirror[item.entry_index] = item.key_value;
		else
			pending_answers.push_back(predict_search(item.key_value));
		items_sent++;
	endtask

	task automatic load_entry(input int idx, input logic signed [KEY_W-1:0] key);
		stbs_in_t item;
		item.action      = ACT_LOAD;
		item.entry_index = ENTRY_W'(idx);
		item.key_value   = key;
		send_item(item);
	endtask

	task automatic search_key(input logic signed [KEY_W-1:0] key);
		stbs_in_t item;
		item.action      = ACT_SEARCH;
		item.entry_index = ENTRY_W'($urandom);
		item.key_value   = key;
		send_item(item);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_count(input int value);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= CFG_W'(value);
		@(posedge clk);
		cfg_wr_en    <= 1'b0;
		count_mirror = value;
	endtask

	task automatic test_empty_table();
		search_key(32'sh8000_0000);
		search_key(32'sh0000_0000);
		search_key(32'sh7fff_ffff);
		settle();
	endtask

	task automatic test_small_tables();
		load_entry(0, 32'sd5);
		settle();
		write_count(1);
		search_key(32'sd5);
		search_key(32'sd4);
		search_key(32'sd6);
		settle();
		write_count(0);
		search_key(32'sd5);
		// duplicate keys
		load_entry(0, 32'sd7);
		load_entry(1, 32'sd7);
		load_entry(2, 32'sd7);
		settle();
		write_count(3);
		search_key(32'sd7);
		// unsorted contents
		load_entry(0, 32'sd9);
		load_entry(1, 32'sd1);
		load_entry(2, 32'sd8);
		load_entry(3, 32'sd2);
		load_entry(4, 32'sd7);
		settle();
		write_count(5);
		search_key(32'sd2);
		search_key(32'sd1);
		search_key(32'sd7);
		settle();
	endtask

	task automatic test_full_table();
		longint v;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			v = -64'sd2147483648 + longint'(i) * 64'sd4194304;
			if (i == TABLE_DEPTH - 1)
				v = v + 64'sd4194303;
			else if (i != 0)
				v = v + longint'($urandom_range(0, 4194303));
			load_entry(i, KEY_W'(v));
		end
		settle();
		write_count(1024);
		search_key(key_mirror[0]);
		search_key(key_mirror[TABLE_DEPTH - 1]);
		search_key(key_mirror[511]);
		search_key(key_mirror[200] + 1);
		settle();
		// count above depth saturates
		write_count(2047);
		search_key(key_mirror[TABLE_DEPTH - 1]);
		settle();
		write_count(1023);
		search_key(key_mirror[TABLE_DEPTH - 1]);
		search_key(key_mirror[TABLE_DEPTH - 2]);
		settle();
	endtask

	task automatic test_random_phases();
		int                      span;
		int                      n;
		int                      reps;
		int                      r;
		bit                      dup_heavy;
		bit                      scramble;
		logic signed [KEY_W-1:0] v;
		logic signed [KEY_W-1:0] k;
		while (items_sent < ITEM_TARGET) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				span = $urandom_range(1, 32);
			else if (r < 85)
				span = $urandom_range(33, 200);
			else if (r < 90)
				span = 1024;
			else if (r < 94)
				span = 2047;
			else if (r < 97)
				span = 1023;
			else
				span = $urandom_range(201, 1022);
			in_idle_on = ($urandom_range(0, 3) != 0);
			n = (span > TABLE_DEPTH) ? TABLE_DEPTH : span;
			if (n <= 200) begin
				dup_heavy = ($urandom_range(0, 3) == 0);
				scramble  = ($urandom_range(0, 9) == 0);
				v = $urandom;
				for (int i = 0; i < n; i++) begin
					load_entry(i, scramble ? KEY_W'($urandom) : v);
					v = v + (dup_heavy ? $urandom_range(0, 2) : $urandom_range(1, 1 << 24));
				end
			end
			settle();
			write_count(span);
			reps = $urandom_range(20, 60);
			for (int j = 0; j < reps; j++) begin
				r = $urandom_range(0, 99);
				if (r < 60) begin
					k = key_mirror[$urandom_range(0, n - 1)];
				end else if (r < 80) begin
					k = key_mirror[$urandom_range(0, n - 1)];
					k = $urandom_range(0, 1) ? k + 1 : k - 1;
				end else if (r < 92) begin
					k = $urandom;
				end else begin
					load_entry($urandom_range(0, n - 1), KEY_W'($urandom));
					continue;
				end
				search_key(k);
			end
		end
		settle();
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_answers.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("unexpected transfer: found %0b position %0d",
						out_data.found, out_data.position);
			end else begin
				wanted = pending_answers.pop_front();
				if (out_data.found !== wanted.found || out_data.position !== wanted.position) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("mismatch: found exp %0b got %0b, position exp %0d got %0d",
							wanted.found, out_data.found, wanted.position, out_data.position);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			out_idle_on = !out_idle_on;
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
			stall_left = pick_gap(out_idle_on);
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_stall    = 1'b0;
		cfg_wr_en    = 1'b0;
		cfg_wr_data  = '0;
		count_mirror = 0;
		items_sent   = 0;
		mismatches   = 0;
		cycle_count  = 0;
		stall_left   = 0;
		in_idle_on   = 1'b1;
		out_idle_on  = 1'b1;
		foreach (key_mirror[i])
			key_mirror[i] = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_small_tables();
		test_full_table();
		test_random_phases();
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
src/stbs_pkg.sv
src/stbs_ram.sv
src/sorted_table_binary_search_core.sv
test/sorted_table_binary_search_core_tb.sv
